// File: sv/ble_adv_structure_filter_assert.svh
// Assertion macros used by the structure filter parser.
`ifndef BLE_ADV_STRUCTURE_FILTER_ASSERT_SVH
`define BLE_ADV_STRUCTURE_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLEASF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("structure filter check failed");

// Next-cycle implication, checked outside reset.
`define BLEASF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("structure filter check failed");

`endif

// File: sv/bleasf_pkg.sv
// Types and constants of the BLE advertising structure filter.
`default_nettype none

package bleasf_pkg;

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_UUID_FIRST  = 2'd0,
    CFG_UUID_SECOND = 2'd1,
    CFG_COMPANY     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_BODY = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  localparam logic [63:0] UUID_FIRST_RESET  = 64'hAAAA_AAAA_BBBB_CCCC;
  localparam logic [63:0] UUID_SECOND_RESET = 64'hDDDD_EEEE_EEEE_EEEE;
  localparam logic [15:0] COMPANY_RESET     = 16'h004C;

  localparam logic [7:0] BEACON_LENGTH = 8'd26;
  localparam logic [7:0] AD_TYPE_MANUF = 8'hFF;
  localparam logic [7:0] AD_TYPE_NAME  = 8'h09;

  localparam logic EVT_BEACON = 1'b0;
  localparam logic EVT_NAME   = 1'b1;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              last_byte;
    logic signed [7:0] report_rssi;
  } in_item_t;

  typedef struct packed {
    logic              event_kind;
    logic [3:0]        device_slot;
    logic [63:0]       name_front;
    logic [7:0]        name_tail;
    logic [3:0]        name_length;
    logic signed [7:0] signal_level;
    logic [15:0]       beacon_major;
    logic [15:0]       beacon_minor;
    logic signed [7:0] beacon_tx_power;
  } out_item_t;

  typedef struct packed {
    logic [63:0] uuid_first_half;
    logic [63:0] uuid_second_half;
    logic [15:0] company_code;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/ble_adv_structure_filter.sv
// Top level of the BLE advertising structure filter.
// Usage:
//   in_*  : one report byte per item, with the last-byte mark and the report RSSI.
//   out_* : one result item per matched beacon structure or captured local name.
//   cfg_* : register writes (index 0/1 UUID halves, 2 company code), always ready;
//           write only while no item is in flight.
// Timing: an accepted byte sits in the input register, where the parse
//   logic evaluates it against the structure state; the result is registered in
//   the output register, which raises out_valid for the structure's final byte.
//   Bytes that end no structure produce no item.
// Throughput: one byte per cycle, set by the single parse stage, except in a stall.
// Reset: parser goes back to expecting a length byte, the name slot count
//   clears and the registers take their default UUID and company code.
// Stall: while out_ready is low and a result waits, bytes that produce no result
//   keep flowing; a byte that would produce one holds in the input register and
//   in_ready drops until the output register frees up.
`default_nettype none

module ble_adv_structure_filter #(
  parameter int MAX_DEVICE_SLOTS = 10,
  parameter int NAME_BYTES_KEPT  = 9
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bleasf_pkg::in_item_t              in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bleasf_pkg::out_item_t                  out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bleasf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]                       cfg_data
);

  bleasf_pkg::cfg_t      cfg;
  logic                  stage_valid, stage_valid_next;
  bleasf_pkg::in_item_t  stage_item;
  logic                  step;
  logic                  hit;
  logic                  free;
  bleasf_pkg::out_item_t result;
  logic                  take;

  assign cfg_ready = 1'b1;

  bleasf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // advance the held byte unless its result has nowhere to go
  assign step     = stage_valid && (!hit || free);
  assign in_ready = !stage_valid || step;
  assign take     = in_valid && in_ready;

  always_comb begin
    stage_valid_next = stage_valid;
    if (take) stage_valid_next = 1'b1;
    else if (step) stage_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) stage_item <= in_data;
  end

  bleasf_parser #(
    .MAX_DEVICE_SLOTS (MAX_DEVICE_SLOTS),
    .NAME_BYTES_KEPT  (NAME_BYTES_KEPT)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (stage_valid),
    .item       (stage_item),
    .step       (step),
    .hit        (hit),
    .result     (result)
  );

  bleasf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && hit),
    .load_data (result),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sv/bleasf_cfg_regs.sv
// Configuration register file: UUID halves and company identifier.
`default_nettype none

module bleasf_cfg_regs (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  wr_en,
  input  wire logic [bleasf_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  wire logic [63:0]                           wr_data,
  output bleasf_pkg::cfg_t                           cfg
);

  bleasf_pkg::cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      case (bleasf_pkg::cfg_reg_t'(wr_index))
        bleasf_pkg::CFG_UUID_FIRST:  cfg_next.uuid_first_half  = wr_data;
        bleasf_pkg::CFG_UUID_SECOND: cfg_next.uuid_second_half = wr_data;
        bleasf_pkg::CFG_COMPANY:     cfg_next.company_code     = wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.uuid_first_half  <= bleasf_pkg::UUID_FIRST_RESET;
      cfg.uuid_second_half <= bleasf_pkg::UUID_SECOND_RESET;
      cfg.company_code     <= bleasf_pkg::COMPANY_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/bleasf_parser.sv
// Length-type-value walker: parse state, beacon match and name capture.
`default_nettype none
`include "ble_adv_structure_filter_assert.svh"

module bleasf_parser #(
  parameter int MAX_DEVICE_SLOTS = 10,
  parameter int NAME_BYTES_KEPT  = 9
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bleasf_pkg::cfg_t     cfg,
  input  wire logic                 item_valid,
  input  wire bleasf_pkg::in_item_t item,
  input  wire logic                 step,
  output logic                      hit,
  output bleasf_pkg::out_item_t     result
);

  bleasf_pkg::phase_t phase, phase_next;
  logic [7:0]  structure_length, structure_length_next;
  logic [7:0]  structure_type, structure_type_next;
  logic [7:0]  byte_position, byte_position_next;
  logic        match_ok, match_ok_next;
  logic [71:0] name_shift, name_shift_next;
  logic [39:0] tail_bytes, tail_bytes_next;
  logic [3:0]  devices_taken, devices_taken_next;

  logic [7:0]   b;
  logic [7:0]   pos_inc;
  logic [127:0] uuid_all;
  logic [3:0]   uuid_idx;
  logic [7:0]   uuid_byte;
  logic         end_of_struct;
  logic         beacon_hit;
  logic         name_hit;
  logic [7:0]   name_count;
  logic [7:0]   type_now;
  logic         match_now;
  logic [71:0]  name_now;
  logic [39:0]  tail_now;

  assign b         = item.data_byte;
  assign pos_inc   = byte_position + 8'd1;
  assign uuid_all  = {cfg.uuid_first_half, cfg.uuid_second_half};
  assign uuid_idx  = 4'(pos_inc - 8'd6);
  // byte i of the UUID sits at bits 127-8i down
  assign uuid_byte = uuid_all[{~uuid_idx, 3'b111} -: 8];
  assign end_of_struct = (phase == bleasf_pkg::PH_BODY) && (pos_inc == structure_length);
  assign name_count    = structure_length - 8'd1;

  // next state
  always_comb begin
    phase_next            = phase;
    structure_length_next = structure_length;
    structure_type_next   = structure_type;
    byte_position_next    = byte_position;
    match_ok_next         = match_ok;
    name_shift_next       = name_shift;
    tail_bytes_next       = tail_bytes;
    case (phase)
      bleasf_pkg::PH_LEN: begin
        if (b == 8'd0) begin
          phase_next = bleasf_pkg::PH_STOP;
        end else begin
          phase_next            = bleasf_pkg::PH_BODY;
          structure_length_next = b;
          structure_type_next   = 8'd0;
          byte_position_next    = 8'd0;
          match_ok_next         = 1'b1;
          name_shift_next       = '0;
          tail_bytes_next       = '0;
        end
      end
      bleasf_pkg::PH_BODY: begin
        byte_position_next = pos_inc;
        if (pos_inc == 8'd1) begin
          structure_type_next = b;
          if (b != bleasf_pkg::AD_TYPE_MANUF || structure_length != bleasf_pkg::BEACON_LENGTH)
            match_ok_next = 1'b0;
        end else if (pos_inc == 8'd2) begin
          if (b != cfg.company_code[7:0]) match_ok_next = 1'b0;
        end else if (pos_inc == 8'd3) begin
          if (b != cfg.company_code[15:8]) match_ok_next = 1'b0;
        end else if (pos_inc >= 8'd6 && pos_inc <= 8'd21) begin
          if (b != uuid_byte) match_ok_next = 1'b0;
        end else if (pos_inc >= 8'd22 && pos_inc <= 8'd26) begin
          tail_bytes_next = {tail_bytes[31:0], b};
        end
        for (int j = 0; j < 9; j++) begin
          if (j < NAME_BYTES_KEPT && pos_inc == 8'(j + 2))
            name_shift_next[71 - 8*j -: 8] = b;
        end
        if (pos_inc == structure_length) phase_next = bleasf_pkg::PH_LEN;
      end
      default: ;
    endcase
    // the structure's final byte may also end the report: keep what it saw
    type_now  = structure_type_next;
    match_now = match_ok_next;
    name_now  = name_shift_next;
    tail_now  = tail_bytes_next;
    // restart at the report boundary
    if (item.last_byte) begin
      phase_next            = bleasf_pkg::PH_LEN;
      structure_length_next = 8'd0;
      structure_type_next   = 8'd0;
      byte_position_next    = 8'd0;
      match_ok_next         = 1'b1;
      name_shift_next       = '0;
      tail_bytes_next       = '0;
    end
  end

  // outputs
  always_comb begin
    beacon_hit = 1'b0;
    name_hit   = 1'b0;
    result     = '0;
    if (end_of_struct) begin
      if (type_now == bleasf_pkg::AD_TYPE_MANUF &&
          structure_length == bleasf_pkg::BEACON_LENGTH && match_now) begin
        beacon_hit = 1'b1;
      end else if (type_now == bleasf_pkg::AD_TYPE_NAME &&
                   devices_taken < 4'(MAX_DEVICE_SLOTS)) begin
        name_hit = 1'b1;
      end
    end
    if (beacon_hit) begin
      result.event_kind      = bleasf_pkg::EVT_BEACON;
      result.signal_level    = item.report_rssi;
      result.beacon_major    = tail_now[39:24];
      result.beacon_minor    = tail_now[23:8];
      result.beacon_tx_power = tail_now[7:0];
    end else if (name_hit) begin
      result.event_kind   = bleasf_pkg::EVT_NAME;
      result.device_slot  = devices_taken;
      result.name_front   = name_now[71:8];
      result.name_tail    = name_now[7:0];
      result.name_length  = (name_count > 8'(NAME_BYTES_KEPT)) ? 4'(NAME_BYTES_KEPT)
                                                               : name_count[3:0];
      result.signal_level = item.report_rssi;
    end
    hit = item_valid && (beacon_hit || name_hit);
  end

  assign devices_taken_next = name_hit ? devices_taken + 4'd1 : devices_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= bleasf_pkg::PH_LEN;
      structure_length <= 8'd0;
      structure_type   <= 8'd0;
      byte_position    <= 8'd0;
      match_ok         <= 1'b1;
      name_shift       <= '0;
      tail_bytes       <= '0;
      devices_taken    <= 4'd0;
    end else if (step) begin
      phase            <= phase_next;
      structure_length <= structure_length_next;
      structure_type   <= structure_type_next;
      byte_position    <= byte_position_next;
      match_ok         <= match_ok_next;
      name_shift       <= name_shift_next;
      tail_bytes       <= tail_bytes_next;
      devices_taken    <= devices_taken_next;
    end
  end

  `BLEASF_ASSERT_NOW(a_slots_bounded, 1'b1, devices_taken <= 4'(MAX_DEVICE_SLOTS))
  `BLEASF_ASSERT_NOW(a_body_inside, phase == bleasf_pkg::PH_BODY, byte_position < structure_length)
  `BLEASF_ASSERT_NEXT(a_report_restart, step && item.last_byte, phase == bleasf_pkg::PH_LEN && byte_position == 8'd0)
  `BLEASF_ASSERT_NEXT(a_slot_taken, step && hit && result.event_kind == bleasf_pkg::EVT_NAME, devices_taken == $past(devices_taken) + 4'd1)

endmodule

`default_nettype wire

// File: sv/bleasf_out_stage.sv
// Result register with valid/ready handshake toward the receiver.
`default_nettype none

module bleasf_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire bleasf_pkg::out_item_t load_data,
  output logic                       free,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output bleasf_pkg::out_item_t      out_data
);

  logic out_valid_next;

  assign free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= load_data;
  end

endmodule

`default_nettype wire

// File: sim/ble_adv_structure_filter_test.sv
// Self-checking testbench: random advertising reports against a byte-level parse predictor.
`timescale 1ns / 1ps

module ble_adv_structure_filter_test;

  localparam int DEVICE_SLOTS    = 10;
  localparam int NAME_KEEP       = 9;
  localparam int PHASES          = 6;
  localparam int BYTES_PER_PHASE = 300;
  localparam int SETTLE_CYCLES   = 6;
  localparam int LONG_HOLD       = 400;

  // Parse predictor and store of expected events.
  class event_scoreboard;
    logic [63:0]           uuid_front;
    logic [63:0]           uuid_back;
    logic [15:0]           company;
    bleasf_pkg::phase_t    phase;
    logic [7:0]            ad_len;
    logic [7:0]            ad_type;
    logic [7:0]            ad_pos;
    bit                    beacon_ok;
    logic [63:0]           name_front;
    logic [7:0]            name_tail;
    logic [39:0]           tail_bytes;
    logic [3:0]            slots_used;
    bleasf_pkg::out_item_t pending_events[$];
    int                    errors;

    function new();
      uuid_front = bleasf_pkg::UUID_FIRST_RESET;
      uuid_back  = bleasf_pkg::UUID_SECOND_RESET;
      company    = bleasf_pkg::COMPANY_RESET;
      slots_used = '0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      phase      = bleasf_pkg::PH_LEN;
      ad_len     = '0;
      ad_type    = '0;
      ad_pos     = '0;
      beacon_ok  = 1'b1;
      name_front = '0;
      name_tail  = '0;
      tail_bytes = '0;
    endfunction

    function void set_reg(bleasf_pkg::cfg_reg_t idx, logic [63:0] val);
      case (idx)
        bleasf_pkg::CFG_UUID_FIRST: begin
          uuid_front = val;
        end
        bleasf_pkg::CFG_UUID_SECOND: begin
          uuid_back = val;
        end
        bleasf_pkg::CFG_COMPANY: begin
          company = val[15:0];
        end
        default: begin
        end
      endcase
    endfunction

    function logic [7:0] uuid_byte(int i);
      if (i < 8) return uuid_front[8*(7-i) +: 8];
      return uuid_back[8*(15-i) +: 8];
    endfunction

    function void note_byte(bleasf_pkg::in_item_t it);
      logic [7:0]            b;
      int                    k;
      int                    n;
      bleasf_pkg::out_item_t ev;
      b = it.data_byte;
      if (phase == bleasf_pkg::PH_LEN) begin
        // a zero length ends parsing until the report ends
        if (b == 8'd0) begin
          phase = bleasf_pkg::PH_STOP;
        end else begin
          restart();
          ad_len = b;
          phase  = bleasf_pkg::PH_BODY;
        end
      end else if (phase == bleasf_pkg::PH_BODY) begin
        ad_pos = ad_pos + 8'd1;
        if (ad_pos == 8'd1) begin
          ad_type = b;
          if (b != bleasf_pkg::AD_TYPE_MANUF || ad_len != bleasf_pkg::BEACON_LENGTH)
            beacon_ok = 1'b0;
        end else if (ad_pos == 8'd2) begin
          if (b != company[7:0]) beacon_ok = 1'b0;
        end else if (ad_pos == 8'd3) begin
          if (b != company[15:8]) beacon_ok = 1'b0;
        end else if (ad_pos >= 8'd6 && ad_pos <= 8'd21) begin
          if (b != uuid_byte(int'(ad_pos) - 6)) beacon_ok = 1'b0;
        end else if (ad_pos >= 8'd22 && ad_pos <= 8'd26) begin
          tail_bytes = {tail_bytes[31:0], b};
        end
        if (ad_pos >= 8'd2) begin
          k = int'(ad_pos) - 2;
          if (k < NAME_KEEP) begin
            if (k < 8) name_front[8*(7-k) +: 8] = b;
            else name_tail = b;
          end
        end
        if (ad_pos == ad_len) begin
          ev = '0;
          if (ad_type == bleasf_pkg::AD_TYPE_MANUF && ad_len == bleasf_pkg::BEACON_LENGTH &&
              beacon_ok) begin
            ev.event_kind      = bleasf_pkg::EVT_BEACON;
            ev.signal_level    = it.report_rssi;
            ev.beacon_major    = tail_bytes[39:24];
            ev.beacon_minor    = tail_bytes[23:8];
            ev.beacon_tx_power = tail_bytes[7:0];
            pending_events.push_back(ev);
          end else if (ad_type == bleasf_pkg::AD_TYPE_NAME && slots_used < DEVICE_SLOTS) begin
            n = int'(ad_len) - 1;
            if (n > NAME_KEEP) n = NAME_KEEP;
            ev.event_kind   = bleasf_pkg::EVT_NAME;
            ev.device_slot  = slots_used;
            ev.name_front   = name_front;
            ev.name_tail    = name_tail;
            ev.name_length  = 4'(n);
            ev.signal_level = it.report_rssi;
            pending_events.push_back(ev);
            slots_used++;
          end
          phase = bleasf_pkg::PH_LEN;
        end
      end
      if (it.last_byte) restart();
    endfunction

    function bit field_differs(string fname, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        if (errors < 10) $display("%s: expected %0h, got %0h", fname, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(bleasf_pkg::out_item_t got);
      bleasf_pkg::out_item_t want;
      bit                    bad;
      if (pending_events.size() == 0) begin
        if (errors < 10) $display("result item with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      bad = 1'b0;
      bad |= field_differs("event_kind", want.event_kind, got.event_kind);
      bad |= field_differs("device_slot", want.device_slot, got.device_slot);
      bad |= field_differs("name_front", want.name_front, got.name_front);
      bad |= field_differs("name_tail", want.name_tail, got.name_tail);
      bad |= field_differs("name_length", want.name_length, got.name_length);
      bad |= field_differs("signal_level", want.signal_level, got.signal_level);
      bad |= field_differs("beacon_major", want.beacon_major, got.beacon_major);
      bad |= field_differs("beacon_minor", want.beacon_minor, got.beacon_minor);
      bad |= field_differs("beacon_tx_power", want.beacon_tx_power, got.beacon_tx_power);
      if (bad) errors++;
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  bleasf_pkg::in_item_t               in_data = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  bleasf_pkg::out_item_t              out_data;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [bleasf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]                        cfg_data = '0;

  event_scoreboard sb;
  logic [7:0]      report_bytes[$];
  int              bytes_sent = 0;
  int              results_seen = 0;
  bit              tx_idle = 1'b0;
  bit              rx_idle = 1'b0;
  bit              streaming = 1'b0;
  bit              long_hold = 1'b0;
  bit              long_done = 1'b0;

  ble_adv_structure_filter #(
    .MAX_DEVICE_SLOTS(DEVICE_SLOTS),
    .NAME_BYTES_KEPT(NAME_KEEP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  function automatic void add_beacon(bit spoil);
    logic [7:0] body[$];
    int         i;
    int         at;
    body.push_back(bleasf_pkg::BEACON_LENGTH);
    body.push_back(bleasf_pkg::AD_TYPE_MANUF);
    body.push_back(sb.company[7:0]);
    body.push_back(sb.company[15:8]);
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    for (i = 0; i < 16; i++) body.push_back(sb.uuid_byte(i));
    repeat (5) body.push_back(8'($urandom));
    if (spoil) begin
      // break one checked byte: length, type, company or UUID
      at = $urandom_range(0, 19);
      if (at >= 4) at = at + 2;
      body[at] = body[at] ^ 8'($urandom_range(1, 255));
    end
    foreach (body[j]) report_bytes.push_back(body[j]);
  endfunction

  function automatic void add_name();
    int len;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 11);
    report_bytes.push_back(8'(len));
    report_bytes.push_back(bleasf_pkg::AD_TYPE_NAME);
    repeat (len - 1) report_bytes.push_back(rand_byte());
  endfunction

  function automatic void add_other();
    int len;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 255) : $urandom_range(1, 8);
    report_bytes.push_back(8'(len));
    report_bytes.push_back(8'($urandom));
    repeat (len - 1) report_bytes.push_back(rand_byte());
  endfunction

  function automatic void build_report();
    int count;
    int r;
    int cut;
    report_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 20)) report_bytes.push_back(8'($urandom));
      return;
    end
    count = $urandom_range(1, 4);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) add_beacon(1'b0);
      else if (r < 52) add_beacon(1'b1);
      else if (r < 67) add_name();
      else add_other();
    end
    r = $urandom_range(0, 99);
    if (r < 15) begin
      // cut the report short inside its structures
      cut = $urandom_range(1, report_bytes.size() - 1);
      repeat (cut) void'(report_bytes.pop_back());
    end else if (r < 25) begin
      report_bytes.push_back(8'h00);
      repeat ($urandom_range(0, 5)) report_bytes.push_back(8'($urandom));
    end else if (r < 30) begin
      report_bytes.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  task automatic push_byte(bleasf_pkg::in_item_t it);
    int gap;
    gap = (tx_idle && !long_hold) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_byte(it);
    bytes_sent++;
  endtask

  task automatic send_report(logic [7:0] rssi);
    bleasf_pkg::in_item_t it;
    foreach (report_bytes[i]) begin
      it.data_byte   = report_bytes[i];
      it.last_byte   = (i == report_bytes.size() - 1);
      it.report_rssi = rssi;
      push_byte(it);
    end
  endtask

  // Drop valid, drain every expected event, then let in-flight bytes clear.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bleasf_pkg::cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: random stalls plus one long hold-off while bytes keep coming.
  initial begin
    int hold;
    hold = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
        if (hold == 0) long_hold = 1'b0;
      end else begin
        out_ready = 1'b1;
        if (!long_done && streaming && results_seen >= 20) begin
          long_done = 1'b1;
          long_hold = 1'b1;
          hold = LONG_HOLD;
        end else if (rx_idle && $urandom_range(0, 3) == 0) begin
          hold = pick_gap();
        end
      end
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
      end
      @(negedge clk);
    end
  end

  initial begin
    int                   ph;
    int                   j;
    int                   target;
    bleasf_pkg::cfg_reg_t idx;
    logic [63:0]          val;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // shortest name, capped name with zero bytes, cut-off structure,
    // zero length, length byte ending the report
    report_bytes = '{8'h01, bleasf_pkg::AD_TYPE_NAME};
    send_report(8'h80);
    report_bytes = '{8'h0B, bleasf_pkg::AD_TYPE_NAME, 8'hFF, 8'h00, 8'h41, 8'h80, 8'h7F,
                     8'h00, 8'h01, 8'hFE, 8'h5A, 8'hA5};
    send_report(8'h7F);
    report_bytes = '{8'h03, bleasf_pkg::AD_TYPE_NAME, 8'h41};
    send_report(8'h00);
    report_bytes = '{8'h00, 8'hFF};
    send_report(8'hC3);
    report_bytes = '{8'h05};
    send_report(8'h3C);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        for (j = 0; j < 3; j++) begin
          idx = bleasf_pkg::cfg_reg_t'((j + ph) % 3);
          if (ph == 1) val = '0;
          else if (ph == 2) val = '1;
          else val = {$urandom, $urandom};
          write_reg(idx, val);
        end
      end
      tx_idle = (ph != 1);
      rx_idle = (ph != 1) && (ph != 4);
      streaming = 1'b1;
      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) begin
        build_report();
        send_report(8'($urandom));
      end
      streaming = 1'b0;
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("[ble_adv_structure_filter] OK");
    end else begin
      $display("[ble_adv_structure_filter] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[ble_adv_structure_filter] ERROR");
    $finish;
  end

endmodule

// File: ble_adv_structure_filter.f
+incdir+sv
sv/bleasf_pkg.sv
sv/bleasf_cfg_regs.sv
sv/bleasf_parser.sv
sv/bleasf_out_stage.sv
sv/ble_adv_structure_filter.sv
sim/ble_adv_structure_filter_test.sv
